// ===== rtl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the WebSocket receive frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // Field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned OPCODE_W = 4;
    localparam int unsigned LIMIT_W  = 16;
    localparam int unsigned LEN_W    = 64;
    localparam int unsigned POS_W    = 17;
    localparam int unsigned HCNT_W   = 3;
    localparam int unsigned KEY_N    = 4;
    localparam int unsigned USER_W   = OPCODE_W + 1;

    // Header constants
    localparam logic [6:0]          LEN_CODE_16   = 7'd126;
    localparam logic [6:0]          LEN_CODE_64   = 7'd127;
    localparam logic [HCNT_W-1:0]   EXT16_COUNT   = 3'd1;
    localparam logic [HCNT_W-1:0]   EXT64_COUNT   = 3'd7;
    localparam logic [1:0]          KEY_LAST_IDX  = 2'd3;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET   = 16'd4095;
    // Saturated position floor: stays at or above 65536
    localparam logic [POS_W-1:0]    POS_FLOOR     = 17'h10000;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HDR0   = 3'd0,
        PH_HDR1   = 3'd1,
        PH_EXTLEN = 3'd2,
        PH_MASK   = 3'd3,
        PH_DATA   = 3'd4
    } phase_t;

    // One result item
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [BYTE_W-1:0]   payload;
        logic                kept;
        logic                last;
    } res_t;

endpackage

// ===== rtl/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// Each result is registered in the output register, or in the skid register
// while the output waits. One byte per cycle while s_tready is high.
// A two-entry output register keeps s_tready high while one result waits.
// Reset (aresetn low, synchronous) returns the parser to the first header
// byte, empties the output stage and sets max_kept_bytes to 4095.
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses WebSocket frames byte by byte and delivers unmasked payload bytes.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Received byte stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,   // [7:0] rx_byte
    // Payload stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [BYTE_W-1:0]   m_tdata,   // [7:0] payload_byte
    output logic [USER_W-1:0]   m_tuser,   // [3:0] frame_opcode, [4] byte_kept
    output logic                m_tlast,   // frame_last
    // Configuration write: max_kept_bytes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LIMIT_W-1:0]  cfg_data
);

    logic [LIMIT_W-1:0] max_kept_reg;
    logic               byte_en;
    logic               res_valid;
    res_t               res;
    res_t               out_res;

    assign cfg_ready = 1'b1;
    assign byte_en   = s_tvalid && s_tready;

    // Kept-byte limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_kept_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            max_kept_reg <= cfg_data;
        end
    end

    wsd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (byte_en),
        .rx_byte   (s_tdata),
        .max_kept  (max_kept_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = out_res.payload;
    assign m_tuser = {out_res.kept, out_res.opcode};
    assign m_tlast = out_res.last;

endmodule

// ===== rtl/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// wsd_parser
// Header parser and payload unmasker. Updates its state on each accepted byte
// and presents the result of that byte combinationally.
// ----------------------------------------------------------------------------
module wsd_parser
    import wsd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_en,
    input  logic [BYTE_W-1:0]   rx_byte,
    input  logic [LIMIT_W-1:0]  max_kept,
    output logic                res_valid,
    output res_t                res
);

    phase_t              phase_reg,  phase_next;
    logic [OPCODE_W-1:0] opcode_reg, opcode_next;
    logic                mask_on_reg, mask_on_next;
    logic [HCNT_W-1:0]   hcnt_reg,   hcnt_next;
    logic [LEN_W-1:0]    len_reg,    len_next;
    logic [POS_W-1:0]    pos_reg,    pos_next;
    logic [BYTE_W-1:0]   key_reg [KEY_N];
    logic                key_we;

    // Helper decodes
    logic [6:0]       len_code;
    logic             is_code16;
    logic             is_code64;
    logic [LEN_W-1:0] len_shift;
    logic             short_zero;
    logic             ext_zero;
    logic             len_zero;
    logic             len_one;
    logic             key_done;
    logic [POS_W:0]   pos_inc;

    assign len_code   = rx_byte[6:0];
    assign is_code16  = (len_code == LEN_CODE_16);
    assign is_code64  = (len_code == LEN_CODE_64);
    assign len_shift  = {len_reg[LEN_W-BYTE_W-1:0], rx_byte};
    assign short_zero = (len_code == 7'd0);
    assign ext_zero   = (len_shift == '0);
    assign len_zero   = (len_reg == '0);
    assign len_one    = (len_reg == {{(LEN_W-1){1'b0}}, 1'b1});
    assign key_done   = (hcnt_reg[1:0] == KEY_LAST_IDX);
    assign pos_inc    = {1'b0, pos_reg} + {{POS_W{1'b0}}, 1'b1};

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (byte_en) begin
            case (phase_reg)
                PH_HDR1: begin
                    if (is_code16 || is_code64) begin
                        phase_next = PH_EXTLEN;
                    end else if (rx_byte[7]) begin
                        phase_next = PH_MASK;
                    end else if (short_zero) begin
                        phase_next = PH_HDR0;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
                PH_EXTLEN: begin
                    if (hcnt_reg == '0) begin
                        if (mask_on_reg) begin
                            phase_next = PH_MASK;
                        end else if (ext_zero) begin
                            phase_next = PH_HDR0;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_MASK: begin
                    if (key_done) begin
                        phase_next = len_zero ? PH_HDR0 : PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (len_one) begin
                        phase_next = PH_HDR0;
                    end
                end
                default: begin
                    phase_next = PH_HDR1;
                end
            endcase
        end
    end

    // Datapath and result
    always_comb begin
        opcode_next  = opcode_reg;
        mask_on_next = mask_on_reg;
        hcnt_next    = hcnt_reg;
        len_next     = len_reg;
        pos_next     = pos_reg;
        key_we       = 1'b0;
        res_valid    = 1'b0;
        res.opcode   = opcode_reg;
        res.payload  = '0;
        res.kept     = 1'b0;
        res.last     = 1'b1;
        if (byte_en) begin
            case (phase_reg)
                PH_HDR1: begin
                    mask_on_next = rx_byte[7];
                    pos_next     = '0;
                    if (is_code16) begin
                        hcnt_next = EXT16_COUNT;
                        len_next  = '0;
                    end else if (is_code64) begin
                        hcnt_next = EXT64_COUNT;
                        len_next  = '0;
                    end else begin
                        len_next = {{(LEN_W-7){1'b0}}, len_code};
                        if (rx_byte[7]) begin
                            hcnt_next = '0;
                        end else if (short_zero) begin
                            res_valid = 1'b1;
                        end
                    end
                end
                PH_EXTLEN: begin
                    len_next = len_shift;
                    if (hcnt_reg == '0) begin
                        pos_next = '0;
                        if (!mask_on_reg && ext_zero) begin
                            res_valid = 1'b1;
                        end
                    end else begin
                        hcnt_next = hcnt_reg - 1'b1;
                    end
                end
                PH_MASK: begin
                    key_we = 1'b1;
                    if (key_done) begin
                        hcnt_next = '0;
                        pos_next  = '0;
                        res_valid = len_zero;
                    end else begin
                        hcnt_next = hcnt_reg + 1'b1;
                    end
                end
                PH_DATA: begin
                    res_valid   = 1'b1;
                    res.payload = mask_on_reg ? (rx_byte ^ key_reg[pos_reg[1:0]]) : rx_byte;
                    res.kept    = (pos_reg < {1'b0, max_kept});
                    res.last    = len_one;
                    len_next    = len_reg - 1'b1;
                    // Saturate, keeping the low two bits for key rotation
                    if (pos_inc[POS_W]) begin
                        pos_next = POS_FLOOR | {{(POS_W-2){1'b0}}, pos_inc[1:0]};
                    end else begin
                        pos_next = pos_inc[POS_W-1:0];
                    end
                end
                default: begin
                    opcode_next = rx_byte[OPCODE_W-1:0];
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR0;
            opcode_reg  <= '0;
            mask_on_reg <= 1'b0;
            hcnt_reg    <= '0;
            pos_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            opcode_reg  <= opcode_next;
            mask_on_reg <= mask_on_next;
            hcnt_reg    <= hcnt_next;
            pos_reg     <= pos_next;
        end
    end

    // Length and mask key
    always_ff @(posedge aclk) begin
        len_reg <= len_next;
        if (key_we) begin
            key_reg[hcnt_reg[1:0]] <= rx_byte;
        end
    end

endmodule

// ===== rtl/wsd_out_buf.sv =====
// ----------------------------------------------------------------------------
// wsd_out_buf
// Two-entry output register with skid stage; keeps input ready while one
// result waits downstream.
// ----------------------------------------------------------------------------
module wsd_out_buf
    import wsd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  res_t in_res,
    output logic in_ready,
    output logic out_valid,
    output res_t out_res,
    input  logic out_ready
);

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_res_reg, out_res_next;
    res_t skid_res_reg, skid_res_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // Refill output from skid first, else from new result
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_res_next   = in_res;
            end
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_res_next   = in_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

endmodule

// ===== verif/websocket_frame_deframer_checker.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_checker
// Watches the byte, payload and limit channels of the deframer, keeps its own
// copy of the frame parser state, and compares every delivered payload request
// field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_checker
    import wsd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Received byte stream
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,   // [7:0] rx_byte
    // Payload stream
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [BYTE_W-1:0]   m_tdata,   // [7:0] payload_byte
    input  logic [USER_W-1:0]   m_tuser,   // [3:0] frame_opcode, [4] byte_kept
    input  logic                m_tlast,   // frame_last
    // Limit writes
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [LIMIT_W-1:0]  cfg_data,
    // Status toward the top
    output int                  fail_count,
    output int                  pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // Parser copy
    phase_t               phase;
    logic [OPCODE_W-1:0]  op_hold;
    logic                 masked;
    logic [HCNT_W-1:0]    hdr_cnt;
    logic [LEN_W-1:0]     bytes_left;
    logic [BYTE_W-1:0]    key [KEY_N];
    logic [POS_W-1:0]     pos;
    logic [LIMIT_W-1:0]   kept_limit;

    // Payload requests predicted but not yet delivered
    res_t payload_due_q[$];

    // Header complete: empty frame gives its end marker, else go to payload
    function void finish_header();
        res_t marker;
        pos = '0;
        if (bytes_left == 0) begin
            phase = PH_HDR0;
            marker.opcode  = op_hold;
            marker.payload = '0;
            marker.kept    = 1'b0;
            marker.last    = 1'b1;
            payload_due_q.push_back(marker);
        end else begin
            phase = PH_DATA;
        end
    endfunction

    // Length known: mask key follows when flagged
    function void finish_length();
        if (masked) begin
            hdr_cnt = '0;
            phase   = PH_MASK;
        end else begin
            finish_header();
        end
    endfunction

    // Advance the parser by one received byte
    function void deframe_byte(logic [BYTE_W-1:0] b);
        logic [6:0]       code;
        logic [POS_W:0]   nxt;
        res_t             r;
        case (phase)
            PH_HDR1: begin
                code       = b[6:0];
                masked     = b[7];
                bytes_left = '0;
                if (code == LEN_CODE_16) begin
                    hdr_cnt = EXT16_COUNT;
                    phase   = PH_EXTLEN;
                end else if (code == LEN_CODE_64) begin
                    hdr_cnt = EXT64_COUNT;
                    phase   = PH_EXTLEN;
                end else begin
                    bytes_left = LEN_W'(code);
                    finish_length();
                end
            end
            PH_EXTLEN: begin
                // big-endian: shift in from the low end
                bytes_left = {bytes_left[LEN_W-BYTE_W-1:0], b};
                if (hdr_cnt == 0)
                    finish_length();
                else
                    hdr_cnt = hdr_cnt - 1'b1;
            end
            PH_MASK: begin
                key[hdr_cnt[1:0]] = b;
                if (hdr_cnt[1:0] == KEY_LAST_IDX) begin
                    hdr_cnt = '0;
                    finish_header();
                end else begin
                    hdr_cnt = hdr_cnt + 1'b1;
                end
            end
            PH_DATA: begin
                r.opcode  = op_hold;
                r.payload = masked ? (b ^ key[pos[1:0]]) : b;
                r.kept    = (pos < {1'b0, kept_limit});
                r.last    = (bytes_left == 1);
                // position saturates above 65535, low bits keep counting
                nxt = {1'b0, pos} + 1'b1;
                if (nxt[POS_W])
                    pos = POS_FLOOR | POS_W'(nxt[1:0]);
                else
                    pos = nxt[POS_W-1:0];
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == 0)
                    phase = PH_HDR0;
                payload_due_q.push_back(r);
            end
            default: begin
                op_hold = b[OPCODE_W-1:0];
                phase   = PH_HDR1;
            end
        endcase
    endfunction

    function void report(string what, res_t want);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t checker: %s", $time, what);
            $display("    expected op %h byte %h kept %b last %b",
                     want.opcode, want.payload, want.kept, want.last);
            $display("    actual   op %h byte %h kept %b last %b",
                     m_tuser[OPCODE_W-1:0], m_tdata, m_tuser[OPCODE_W], m_tlast);
        end
    endfunction

    // Compare a delivered payload request with the oldest prediction
    function void check_payload();
        res_t want;
        if (payload_due_q.size() == 0) begin
            report("payload with nothing due", '0);
        end else begin
            want = payload_due_q.pop_front();
            if (m_tuser[OPCODE_W-1:0] != want.opcode || m_tdata != want.payload ||
                m_tuser[OPCODE_W] != want.kept || m_tlast != want.last)
                report("payload mismatch", want);
        end
    endfunction

    // Outputs are retired before inputs: a byte's result cannot leave on the
    // edge that takes the byte in
    always @(posedge aclk) begin
        if (!aresetn) begin
            phase      = PH_HDR0;
            op_hold    = '0;
            masked     = 1'b0;
            hdr_cnt    = '0;
            bytes_left = '0;
            pos        = '0;
            kept_limit = LIMIT_RESET;
            for (int i = 0; i < KEY_N; i++)
                key[i] = '0;
            payload_due_q.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready)
                check_payload();
            if (cfg_valid && cfg_ready)
                kept_limit = cfg_data;
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata);
        end
        pending_count = payload_due_q.size();
    end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives WebSocket frames into the deframer byte by byte: a few hand-built
// frames, then random frames under several kept-byte limits with random gaps
// on one or both streams, and a closing frame whose 64-bit length has its top bit set.
// ----------------------------------------------------------------------------
module testbench
    import wsd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_MAX       = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 650;
    localparam int PHASES         = 6;

    // Length encodings of a frame header
    typedef enum int {ENC_SHORT, ENC_EXT16, ENC_EXT64} len_enc_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata;    // [7:0] rx_byte
    logic                m_tvalid;
    logic                m_tready;
    logic [BYTE_W-1:0]   m_tdata;    // [7:0] payload_byte
    logic [USER_W-1:0]   m_tuser;    // [3:0] frame_opcode, [4] byte_kept
    logic                m_tlast;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [LIMIT_W-1:0]  cfg_data;

    int fail_count;
    int pending_count;
    int items_sent;
    int stall_cycles;
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_request;

    websocket_frame_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    websocket_frame_deframer_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Watchdog: ends the run when no request of any channel moves
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Payload receiver: random gap per request, one long hold on demand
    initial begin
        int gap;
        m_tready = 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            gap = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // One byte request; starts and ends at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!(s_tvalid && s_tready)) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_payload(input longint unsigned n);
        for (longint unsigned i = 0; i < n; i++)
            send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    // Header bytes, extended length and, if masked, a random key
    task automatic send_header(input logic [BYTE_W-1:0] first, input logic mask,
                               input logic [LEN_W-1:0] len, input len_enc_t enc);
        send_byte(first);
        case (enc)
            ENC_EXT16: begin
                send_byte({mask, LEN_CODE_16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            ENC_EXT64: begin
                send_byte({mask, LEN_CODE_64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8*i +: 8]);
            end
            default: send_byte({mask, len[6:0]});
        endcase
        if (mask)
            send_payload(KEY_N);
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] first, input logic mask,
                              input logic [LEN_W-1:0] len, input len_enc_t enc);
        send_header(first, mask, len, enc);
        send_payload(len);
    endtask

    // Mostly short frames, some medium, a few over 125 bytes
    task automatic random_frame();
        int       pick;
        int       len;
        len_enc_t enc;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            len = $urandom_range(0, 6);
        else if (pick < 95)
            len = $urandom_range(7, 40);
        else
            len = $urandom_range(126, 180);
        pick = $urandom_range(0, 99);
        if (len > 125)
            enc = (pick < 50) ? ENC_EXT16 : ENC_EXT64;
        else if (pick < 80)
            enc = ENC_SHORT;
        else if (pick < 90)
            enc = ENC_EXT16;
        else
            enc = ENC_EXT64;
        send_frame(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   LEN_W'(len), enc);
    endtask

    // Sender rests until every predicted payload request has been delivered
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!(cfg_valid && cfg_ready)) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [LIMIT_W-1:0] limits [PHASES];
        int                 phase_end;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        items_sent   = 0;
        stall_cycles = 0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        hold_request = 1'b0;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Hand-built frames under the reset limit
        send_frame(8'h81, 1'b0, '0, ENC_SHORT);          // empty, unmasked
        send_frame(8'h8A, 1'b1, '0, ENC_SHORT);          // empty, masked
        send_header(8'h02, 1'b0, 64'd3, ENC_SHORT);      // passes through as is
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_frame(8'hFF, 1'b1, 64'd4, ENC_SHORT);       // unmasked with the key

        // Random frames under several limits, idling varied per phase
        limits[0] = '0;
        limits[1] = 16'd1;
        limits[2] = 16'd3;
        limits[3] = LIMIT_W'($urandom_range(0, 10));
        limits[4] = LIMIT_W'($urandom_range(0, 65535));
        limits[5] = '1;
        for (int p = 0; p < PHASES; p++) begin
            write_limit(limits[p]);
            tx_idle_on = (p % 3 != 1);
            rx_idle_on = (p % 3 != 2);
            phase_end  = items_sent + RANDOM_ITEMS / PHASES;
            if (p == 1)
                hold_request = 1'b1;    // sender keeps going while payload backs up
            while (items_sent < phase_end) begin
                random_frame();
                if (p == 3 && items_sent >= phase_end - RANDOM_ITEMS / (2 * PHASES)
                    && pending_count != 0)
                    drain();
            end
        end

        // Length with the top bit set never ends, so it closes the run
        write_limit(LIMIT_W'($urandom_range(0, 20)));
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_header(BYTE_W'($urandom_range(0, 255)), 1'b1,
                    64'h8000_0000_0000_0000 | LEN_W'($urandom_range(0, 255)), ENC_EXT64);
        send_payload(20);

        drain();
        if (fail_count == 0 && pending_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
